// ===== hdl/hed_pkg.sv =====
// Shared types and constants for the HTML entity decoder.
package hed_pkg;

	localparam int HOLD_DEPTH = 5;
	localparam int CAND_LEN   = HOLD_DEPTH + 1;
	localparam int N_ENT      = 7;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int CFG_ADDR_W = 3;

	localparam logic [7:0]  CHAR_AMP        = 8'h26;
	localparam logic [15:0] CAP_RESET       = 16'd4095;
	localparam logic [0:0]  REG_OUTPUT_CAP  = 1'b0;

	localparam logic [7:0] ENT_TEXT [N_ENT][CAND_LEN] = '{
		'{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},
		'{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},
		'{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},
		'{8'h26, 8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b},
		'{8'h26, 8'h23, 8'h33, 8'h39, 8'h3b, 8'h00},
		'{8'h26, 8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b},
		'{8'h26, 8'h6e, 8'h62, 8'h73, 8'h70, 8'h3b}
	};
	localparam logic [3:0] ENT_LEN [N_ENT] = '{4'd4, 4'd4, 4'd5, 4'd6, 4'd5, 4'd6, 4'd6};
	localparam logic [7:0] ENT_VAL [N_ENT] = '{8'h3c, 8'h3e, 8'h26, 8'h22, 8'h27, 8'h27, 8'h20};

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_flag;
	} hed_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_terminator;
		logic       run_last;
	} hed_out_t;

	typedef struct packed {
		logic [CAND_LEN-1:0][7:0] data;
		logic [2:0]               count;
		logic                     term;
	} hed_job_t;

endpackage

// ===== hdl/hed_front.sv =====
// Front end: entity matching, prefix holding and output capacity accounting.
module hed_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  hed_pkg::hed_in_t    in_data,
	input  logic [15:0]         capacity,
	output logic                job_push,
	output hed_pkg::hed_job_t   job
);
	import hed_pkg::*;

	logic [7:0]               held_q [HOLD_DEPTH];
	logic [2:0]               held_count_q;
	logic [15:0]              emitted_count_q;

	logic [CAND_LEN-1:0][7:0] cand;
	logic [3:0]               m_len;
	logic                     hit_full;
	logic                     hit_prefix;
	logic [7:0]               full_val;
	logic                     extend;
	logic                     is_amp;
	logic                     last;
	logic [2:0]               n_data;
	logic [2:0]               k_data;
	logic [15:0]              room;
	logic [2:0]               new_held;
	logic                     wr_held;
	logic [2:0]               wr_idx;

	assign last   = in_data.end_flag;
	assign is_amp = (in_data.in_byte == CHAR_AMP);
	assign m_len  = {1'b0, held_count_q} + 4'd1;

	always_comb begin
		for (int i = 0; i < HOLD_DEPTH; i++) begin
			cand[i] = (3'(i) < held_count_q) ? held_q[i] : in_data.in_byte;
		end
		cand[CAND_LEN-1] = in_data.in_byte;
	end

	always_comb begin
		logic ok;
		hit_full   = 1'b0;
		hit_prefix = 1'b0;
		full_val   = 8'h00;
		for (int e = 0; e < N_ENT; e++) begin
			ok = (m_len <= ENT_LEN[e]);
			for (int i = 0; i < CAND_LEN; i++) begin
				if (4'(i) < m_len && cand[i] != ENT_TEXT[e][i]) begin
					ok = 1'b0;
				end
			end
			if (ok && held_count_q != 3'd0) begin
				if (m_len == ENT_LEN[e]) begin
					hit_full = 1'b1;
					full_val = ENT_VAL[e];
				end else begin
					hit_prefix = 1'b1;
				end
			end
		end
	end

	assign extend = !hit_full && hit_prefix && (held_count_q < 3'(HOLD_DEPTH));

	always_comb begin
		wr_held = 1'b0;
		wr_idx  = 3'd0;
		if (hit_full) begin
			n_data   = 3'd1;
			new_held = 3'd0;
		end else if (extend) begin
			n_data   = last ? held_count_q + 3'd1 : 3'd0;
			new_held = last ? 3'd0 : held_count_q + 3'd1;
			wr_held  = !last;
			wr_idx   = held_count_q;
		end else if (is_amp) begin
			n_data   = held_count_q + {2'b00, last};
			new_held = last ? 3'd0 : 3'd1;
			wr_held  = !last;
		end else begin
			n_data   = held_count_q + 3'd1;
			new_held = 3'd0;
		end
	end

	assign room   = capacity - emitted_count_q;
	assign k_data = (emitted_count_q >= capacity) ? 3'd0 :
	                (room < 16'(n_data)) ? room[2:0] : n_data;

	always_comb begin
		job.data = cand;
		if (hit_full) begin
			job.data[0] = full_val;
		end
		job.count = k_data;
		job.term  = last;
	end

	assign job_push = accept && (k_data != 3'd0 || last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q    <= 3'd0;
			emitted_count_q <= 16'd0;
		end else if (accept) begin
			held_count_q    <= new_held;
			emitted_count_q <= last ? 16'd0 : emitted_count_q + 16'(k_data);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && wr_held) begin
			held_q[wr_idx] <= in_data.in_byte;
		end
	end

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q <= 3'(HOLD_DEPTH))
		else $error("held count exceeds hold depth");

	a_held_amp: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q != 3'd0 |-> held_q[0] == CHAR_AMP)
		else $error("held prefix does not start with an ampersand");

endmodule

// ===== hdl/hed_queue.sv =====
// Short job queue between the front end and the result serializer.
module hed_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  hed_pkg::hed_job_t wr_job,
	output logic              full,
	input  logic              rd,
	output hed_pkg::hed_job_t rd_job,
	output logic              empty
);
	import hed_pkg::*;

	hed_job_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_wr;
	logic              do_rd;

	assign full   = (count_q == (QPTR_W+1)'(QDEPTH));
	assign empty  = (count_q == '0);
	assign do_wr  = wr && !full;
	assign do_rd  = rd && !empty;
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W+1)'(QDEPTH))
		else $error("queue count exceeds depth");

endmodule

// ===== hdl/hed_back.sv =====
// Back end: turns queued jobs into single results in an output register.
module hed_back (
	input  logic              clk,
	input  logic              arst_n,
	input  hed_pkg::hed_job_t head,
	input  logic              head_empty,
	output logic              head_pop,
	output hed_pkg::hed_out_t out_data,
	output logic              empty,
	input  logic              pop
);
	import hed_pkg::*;

	logic [2:0] idx_q;
	logic       out_valid_q;
	hed_out_t   out_q;
	hed_out_t   cur;
	logic       load;
	logic       in_data_part;

	assign in_data_part = (idx_q < head.count);

	always_comb begin
		if (in_data_part) begin
			cur.out_byte      = head.data[idx_q];
			cur.is_terminator = 1'b0;
			cur.run_last      = (idx_q == head.count - 3'd1) && !head.term;
		end else begin
			cur.out_byte      = 8'h00;
			cur.is_terminator = 1'b1;
			cur.run_last      = 1'b1;
		end
	end

	assign load     = !head_empty && (!out_valid_q || pop);
	assign head_pop = load && cur.run_last;
	assign out_data = out_q;
	assign empty    = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= cur.run_last ? 3'd0 : idx_q + 3'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= cur;
		end
	end

	a_term_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.is_terminator |-> out_q.out_byte == 8'h00 && out_q.run_last)
		else $error("terminator result with data or without run end");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		!head_empty |-> (idx_q < head.count) || head.term)
		else $error("serializer index past the end of its job");

endmodule

// ===== hdl/html_entity_decoder_top.sv =====
// Top level of the streaming HTML entity decoder with its register port.
//
// Input channel: one encoded byte per transfer, with end_flag on the last
// byte of a string; a transfer happens when push is high and full is low.
// Result channel: decoded bytes, then a zero terminator result per string;
// the oldest result is shown while empty is low and leaves on pop.
// run_last marks the last result that one input byte causes.
// Register output_capacity (byte address 0) limits data bytes per string.
// A result waits in the job queue, then in the result register.
// Throughput: one input byte per cycle while each byte gives at most one
// result and the receiver pops; the serializer emits one result per cycle
// while it pops; a four-job queue absorbs a mismatch flush or end of string.
// When the receiver stalls, the result register holds one result and full
// rises once four jobs wait in the queue behind it.
// Reset clears the held prefix, the byte count and the queue; capacity
// returns to 4095.
module html_entity_decoder_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  hed_pkg::hed_in_t                   in_data,
	output logic                               empty,
	input  logic                               pop,
	output hed_pkg::hed_out_t                  out_data,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [hed_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	import hed_pkg::*;

	logic [15:0] capacity_q;
	logic        accept;
	logic        job_push;
	hed_job_t    job;
	hed_job_t    head;
	logic        head_empty;
	logic        head_pop;
	logic        reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[CFG_ADDR_W-1] == REG_OUTPUT_CAP);
	assign prdata  = reg_sel ? {16'd0, capacity_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			capacity_q <= pwdata[15:0];
		end
	end

	assign accept = push && !full;

	hed_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_data  (in_data),
		.capacity (capacity_q),
		.job_push (job_push),
		.job      (job)
	);

	hed_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_push),
		.wr_job (job),
		.full   (full),
		.rd     (head_pop),
		.rd_job (head),
		.empty  (head_empty)
	);

	hed_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_empty (head_empty),
		.head_pop   (head_pop),
		.out_data   (out_data),
		.empty      (empty),
		.pop        (pop)
	);

endmodule
